>>> hdl/mdf_pkg.sv
// shared types and constants for the message deframer
`timescale 1ns / 1ps
`default_nettype none

package mdf_pkg;

	localparam int MODE_W     = 2;
	localparam int MAX_LEN_W  = 22;
	localparam int HDR_W      = 32;
	localparam int BYTE_W     = 8;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	typedef logic [MODE_W-1:0]    mode_t;
	typedef logic [MAX_LEN_W-1:0] len_t;
	typedef logic [BYTE_W-1:0]    byte_t;

	localparam mode_t MODE_LEN16_BE = 2'd0;
	localparam mode_t MODE_LEN32_LE = 2'd1;
	localparam mode_t MODE_LINE     = 2'd2;
	localparam mode_t MODE_TELNET   = 2'd3;

	// register index, taken from paddr[2]
	localparam logic REG_FRAME_MODE = 1'b0;
	localparam logic REG_MAX_LENGTH = 1'b1;

	localparam len_t MAX_LENGTH_RST = 22'd4096;

	localparam byte_t CHAR_LF = 8'd10;
	localparam byte_t CHAR_CR = 8'd13;
	localparam byte_t CHAR_IAC = 8'd255;

	localparam logic [1:0] TELNET_TAIL = 2'd2;

	typedef struct packed {
		mode_t frame_mode;
		len_t  max_length;
		logic  mode_wr;
	} cfg_t;

	typedef struct packed {
		byte_t payload_byte;
		logic  last_of_message;
		logic  empty_line;
		logic  telnet_command;
		logic  framing_error;
	} res_t;

endpackage

`default_nettype wire

>>> hdl/mdf_if.sv
// valid/ready channel interfaces for received bytes and message results
`timescale 1ns / 1ps
`default_nettype none

interface mdf_byte_if;
	logic               valid;
	logic               ready;
	mdf_pkg::byte_t     data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface mdf_msg_if;
	logic           valid;
	logic           ready;
	mdf_pkg::byte_t payload_byte;
	logic           last_of_message;
	logic           empty_line;
	logic           telnet_command;
	logic           framing_error;

	modport source (output valid, output payload_byte, output last_of_message,
		output empty_line, output telnet_command, output framing_error, input ready);
	modport sink (input valid, input payload_byte, input last_of_message,
		input empty_line, input telnet_command, input framing_error, output ready);
endinterface

`default_nettype wire

>>> hdl/mdf_cfg_regs.sv
// apb configuration registers: frame mode and length limit
`timescale 1ns / 1ps
`default_nettype none

module mdf_cfg_regs (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire  [mdf_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire  [mdf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [mdf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	output mdf_pkg::cfg_t                      cfg
);
	import mdf_pkg::*;

	mode_t frame_mode_q;
	len_t  max_length_q;
	logic  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q <= MODE_LEN16_BE;
			max_length_q <= MAX_LENGTH_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_FRAME_MODE: frame_mode_q <= pwdata[MODE_W-1:0];
				REG_MAX_LENGTH: max_length_q <= pwdata[MAX_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FRAME_MODE: prdata = {{(APB_DATA_W-MODE_W){1'b0}}, frame_mode_q};
			REG_MAX_LENGTH: prdata = {{(APB_DATA_W-MAX_LEN_W){1'b0}}, max_length_q};
			default:        prdata = '0;
		endcase
	end

	assign cfg.frame_mode = frame_mode_q;
	assign cfg.max_length = max_length_q;
	assign cfg.mode_wr    = wr_en && (paddr[2] == REG_FRAME_MODE);

endmodule

`default_nettype wire

>>> hdl/mdf_frame_fsm.sv
// framing state machine: header, payload, line and telnet handling
`timescale 1ns / 1ps
`default_nettype none

module mdf_frame_fsm #(
	parameter int LENGTH_BITS = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  mdf_pkg::cfg_t        cfg,
	input  wire                  step,
	input  mdf_pkg::byte_t       data_byte,
	output logic                 res_valid,
	output mdf_pkg::res_t        res
);
	import mdf_pkg::*;

	typedef enum logic [1:0] {PH_START, PH_PAYLOAD, PH_TELNET, PH_ERROR} phase_t;

	phase_t                 phase_q, phase_nxt;
	logic [1:0]             hc_q, hc_nxt;
	logic [HDR_W-1:0]       hdr_q, hdr_nxt;
	logic [LENGTH_BITS-1:0] rem_q, rem_nxt;
	len_t                   len_q, len_nxt;
	byte_t                  held_q, held_nxt;
	logic [1:0]             tel_q, tel_nxt;
	logic                   len_mode;
	logic                   hdr_done;
	logic                   hdr_bad;
	logic                   is_term;

	assign len_mode = (cfg.frame_mode == MODE_LEN16_BE) || (cfg.frame_mode == MODE_LEN32_LE);
	assign is_term  = (data_byte == CHAR_LF) || (data_byte == CHAR_CR);

	always_comb begin
		hdr_nxt = hdr_q;
		if (cfg.frame_mode == MODE_LEN16_BE)
			hdr_nxt = {{(HDR_W-16){1'b0}}, hdr_q[7:0], data_byte};
		else
			hdr_nxt[8*hc_q +: 8] = data_byte;
	end

	assign hdr_done = (cfg.frame_mode == MODE_LEN16_BE) ? (hc_q == 2'd1) : (hc_q == 2'd3);
	assign hdr_bad  = (hdr_nxt == '0)
		|| (hdr_nxt > {{(HDR_W-MAX_LEN_W){1'b0}}, cfg.max_length})
		|| (({1'b0, hdr_nxt} >> LENGTH_BITS) != '0);

	always_comb begin
		phase_nxt = phase_q;
		hc_nxt    = hc_q;
		rem_nxt   = rem_q;
		len_nxt   = len_q;
		held_nxt  = held_q;
		tel_nxt   = tel_q;
		res_valid = 1'b0;
		res       = '0;
		if (cfg.mode_wr) begin
			if (phase_q != PH_ERROR) begin
				phase_nxt = PH_START;
				hc_nxt    = '0;
				rem_nxt   = '0;
				len_nxt   = '0;
				held_nxt  = '0;
				tel_nxt   = '0;
			end
		end else if (step) begin
			unique case (phase_q)
				PH_ERROR: ;
				PH_PAYLOAD: begin
					res_valid        = 1'b1;
					res.payload_byte = data_byte;
					rem_nxt          = rem_q - LENGTH_BITS'(1);
					if (rem_q == LENGTH_BITS'(1)) begin
						res.last_of_message = 1'b1;
						phase_nxt           = PH_START;
					end
				end
				PH_TELNET: begin
					res_valid          = 1'b1;
					res.payload_byte   = data_byte;
					res.telnet_command = 1'b1;
					tel_nxt            = tel_q - 2'd1;
					if (tel_q == 2'd1) begin
						res.last_of_message = 1'b1;
						phase_nxt           = PH_START;
					end
				end
				PH_START: begin
					if (len_mode) begin
						hc_nxt = hc_q + 2'd1;
						if (hdr_done) begin
							hc_nxt = '0;
							if (hdr_bad) begin
								phase_nxt         = PH_ERROR;
								res_valid         = 1'b1;
								res.framing_error = 1'b1;
								rem_nxt           = '0;
							end else begin
								phase_nxt = PH_PAYLOAD;
								rem_nxt   = hdr_nxt[LENGTH_BITS-1:0];
							end
						end
					end else if (is_term) begin
						res_valid           = 1'b1;
						res.last_of_message = 1'b1;
						if (len_q == '0)
							res.empty_line = 1'b1;
						else
							res.payload_byte = held_q;
						len_nxt  = '0;
						held_nxt = '0;
					end else if ((cfg.frame_mode == MODE_TELNET) && (len_q == '0)
						&& (data_byte == CHAR_IAC)) begin
						res_valid          = 1'b1;
						res.payload_byte   = data_byte;
						res.telnet_command = 1'b1;
						phase_nxt          = PH_TELNET;
						tel_nxt            = TELNET_TAIL;
					end else if (len_q >= cfg.max_length) begin
						phase_nxt         = PH_ERROR;
						res_valid         = 1'b1;
						res.framing_error = 1'b1;
						len_nxt           = '0;
						held_nxt          = '0;
					end else begin
						if (len_q != '0) begin
							res_valid        = 1'b1;
							res.payload_byte = held_q;
						end
						held_nxt = data_byte;
						len_nxt  = len_q + MAX_LEN_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// header word is cleared when a header completes or frame_mode is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			hc_q    <= '0;
			hdr_q   <= '0;
			rem_q   <= '0;
			len_q   <= '0;
			held_q  <= '0;
			tel_q   <= '0;
		end else begin
			phase_q <= phase_nxt;
			hc_q    <= hc_nxt;
			rem_q   <= rem_nxt;
			len_q   <= len_nxt;
			held_q  <= held_nxt;
			tel_q   <= tel_nxt;
			if (cfg.mode_wr || (step && len_mode && (phase_q == PH_START) && hdr_done))
				hdr_q <= '0;
			else if (step && len_mode && (phase_q == PH_START))
				hdr_q <= hdr_nxt;
		end
	end

endmodule

`default_nettype wire

>>> hdl/mdf_out_reg.sv
// result register driving the message channel
`timescale 1ns / 1ps
`default_nettype none

module mdf_out_reg (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                load,
	input  mdf_pkg::res_t      res,
	output logic               free,
	mdf_msg_if.source          msg
);
	import mdf_pkg::*;

	logic valid_q;
	res_t res_q;

	assign free = !valid_q || msg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign msg.valid           = valid_q;
	assign msg.payload_byte    = res_q.payload_byte;
	assign msg.last_of_message = res_q.last_of_message;
	assign msg.empty_line      = res_q.empty_line;
	assign msg.telnet_command  = res_q.telnet_command;
	assign msg.framing_error   = res_q.framing_error;

endmodule

`default_nettype wire

>>> hdl/message_deframer.sv
// top level of the message deframer
// splits a received byte stream into messages, one byte per transfer on rx.
// rx carries one byte; msg carries at most one result per byte: a payload byte
// with last_of_message, an empty line, a telnet command byte or a framing error.
// frame_mode selects a 2-byte big-endian or 4-byte little-endian length header,
// line mode, or line mode with telnet commands; max_length bounds messages and
// lines. both registers sit on the apb port at byte addresses 0 and 4.
// an accepted byte lands in the input register; the framing state machine
// handles it from there once the result register is free or being read and
// loads its result into the result register, which drives msg. one byte per
// cycle is taken while the result register is free or being read; line bytes
// come out one byte late so the terminator can carry the last mark.
// reset returns to header/line start with mode 0 and a limit of 4096 and clears
// a framing error, which otherwise blocks all further results.
// when msg stalls the result register holds and rx ready drops as soon as the
// input register holds a byte that cannot move on; if the input register is
// empty at that point one more byte is taken first.
`timescale 1ns / 1ps
`default_nettype none

module message_deframer #(
	parameter int LENGTH_BITS = 32
) (
	input  wire                               clk,
	input  wire                               arst_n,
	mdf_byte_if.sink                          rx,
	mdf_msg_if.source                         msg,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [mdf_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire  [mdf_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [mdf_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);
	import mdf_pkg::*;

	cfg_t  cfg;
	logic  valid_s1;
	byte_t byte_s1;
	logic  out_free;
	logic  step;
	logic  res_valid;
	res_t  res;

	assign step     = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.data_byte;
		end
	end

	mdf_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mdf_frame_fsm #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.data_byte (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	mdf_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && res_valid),
		.res    (res),
		.free   (out_free),
		.msg    (msg)
	);

endmodule

`default_nettype wire

>>> hdl/mdf_checker.sv
// port-level checks for the message deframer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module mdf_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       msg_valid,
	input wire       msg_ready,
	input wire [7:0] msg_payload_byte,
	input wire       msg_last_of_message,
	input wire       msg_empty_line,
	input wire       msg_telnet_command,
	input wire       msg_framing_error
);

	logic err_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (msg_valid && msg_ready && msg_framing_error) begin
			err_seen_q <= 1'b1;
		end
	end

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_seen_q |-> !msg_valid)
		else $error("result after framing error transfer");

	a_error_alone: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_framing_error |->
			!msg_last_of_message && !msg_empty_line && !msg_telnet_command)
		else $error("framing error combined with other flags");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_empty_line |-> msg_last_of_message && !msg_telnet_command)
		else $error("empty line without last mark");

	a_msg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && !msg_ready |=> msg_valid && $stable(msg_payload_byte)
			&& $stable(msg_last_of_message))
		else $error("stalled result changed");

endmodule

bind message_deframer mdf_checker u_mdf_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.msg_valid           (msg.valid),
	.msg_ready           (msg.ready),
	.msg_payload_byte    (msg.payload_byte),
	.msg_last_of_message (msg.last_of_message),
	.msg_empty_line      (msg.empty_line),
	.msg_telnet_command  (msg.telnet_command),
	.msg_framing_error   (msg.framing_error)
);

`default_nettype wire
